// ===== sv/cur_pkg.sv =====
`timescale 1ns / 1ps

package cur_pkg;

	localparam logic [7:0] TAG_EXPECTED = 8'h99;

	localparam int KEY_W = 32;
	localparam int SUM_W = 12;

	typedef struct packed {
		logic [KEY_W-1:0] co0;
		logic [KEY_W-1:0] co1;
		logic [KEY_W-1:0] co2;
		logic [KEY_W-1:0] co3;
		logic [7:0]       s0;
		logic [7:0]       s1;
		logic [7:0]       seed_out;
		logic             bad;
	} mix_t;

endpackage

// ===== sv/colorimeter_unlock_response_unit.sv =====
`timescale 1ns / 1ps
// A word accepted with start high passes through the input, product and result registers
// and then appears on the result ports with done high.
// Throughput: one word per cycle; busy is always low, and the two 32x32 multipliers
// in the product stage set the length of the longest path.
// Reset clears both key registers to zero and drops every pipeline valid bit; the
// receiver cannot stall, so each result is shown for exactly one cycle.

module colorimeter_unlock_response_unit
	import cur_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  reply_tag,
	input  logic [7:0]  seed_out,
	input  logic [7:0]  seed_in,
	input  logic [63:0] challenge_bytes,
	output logic        done,
	output logic [63:0] response_low,
	output logic [63:0] response_high,
	output logic        bad_reply,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [KEY_W-1:0] key_first_q;
	logic [KEY_W-1:0] key_second_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= '0;
			key_second_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				key_second_q <= pwdata;
			end else begin
				key_first_q <= pwdata;
			end
		end
	end

	assign prdata = paddr[2] ? key_second_q : key_first_q;

	logic        valid_s1;
	logic [7:0]  tag_s1;
	logic [7:0]  sout_s1;
	logic [7:0]  sin_s1;
	logic [63:0] ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			tag_s1  <= reply_tag;
			sout_s1 <= seed_out;
			sin_s1  <= seed_in;
			ch_s1   <= challenge_bytes;
		end
	end

	logic [7:0]       sc [8];
	logic [KEY_W-1:0] ci0;
	logic [KEY_W-1:0] ci1;
	logic [KEY_W-1:0] nk0;
	logic [KEY_W-1:0] nk1;
	logic [SUM_W-1:0] sum;
	logic [7:0]       nk0_tot;
	logic [7:0]       nk1_tot;
	mix_t             mix_d;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sc[i] = ch_s1[8*i +: 8] ^ sin_s1;
		end
		ci0 = {sc[3], sc[0], sc[4], sc[6]};
		ci1 = {sc[1], sc[7], sc[2], sc[5]};
		nk0 = '0 - key_first_q;
		nk1 = '0 - key_second_q;
		nk0_tot = nk0[7:0] + nk0[15:8] + nk0[23:16] + nk0[31:24];
		nk1_tot = nk1[7:0] + nk1[15:8] + nk1[23:16] + nk1[31:24];
		sum = SUM_W'(nk0_tot) + SUM_W'(nk1_tot);
		for (int i = 0; i < 8; i++) begin
			sum = sum + SUM_W'(sc[i]);
		end
		mix_d.co0      = nk0 - ci1;
		mix_d.co1      = nk1 - ci0;
		mix_d.co2      = ci1 * nk0;
		mix_d.co3      = ci0 * nk1;
		mix_d.s0       = sum[7:0];
		mix_d.s1       = {4'b0000, sum[11:8]};
		mix_d.seed_out = sout_s1;
		mix_d.bad      = (tag_s1 != TAG_EXPECTED);
	end

	logic valid_s2;
	mix_t mix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mix_s2 <= mix_d;
		end
	end

	logic [63:0] lo_d;
	logic [63:0] hi_d;

	cur_resp_mix u_mix (
		.mix (mix_s2),
		.lo  (lo_d),
		.hi  (hi_d)
	);

	logic        done_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic        bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			lo_q  <= lo_d;
			hi_q  <= hi_d;
			bad_q <= mix_s2.bad;
		end
	end

	assign done          = done_q;
	assign response_low  = lo_q;
	assign response_high = hi_q;
	assign bad_reply     = bad_q;

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word did not produce a result three cycles later");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2) && $past(valid_s1, 2))
		else $error("result strobe without a word in the pipeline");

	a_bad_tracks_tag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ##1 (bad_reply == $past(tag_s1 != TAG_EXPECTED, 2)))
		else $error("bad reply flag does not match the reply tag");

endmodule

// ===== sv/cur_resp_mix.sv =====
`timescale 1ns / 1ps

module cur_resp_mix
	import cur_pkg::*;
(
	input  mix_t        mix,
	output logic [63:0] lo,
	output logic [63:0] hi
);

	logic [7:0] r [16];

	always_comb begin
		r[0]  = mix.co0[23:16] + mix.s0;
		r[1]  = mix.co2[15:8]  - mix.s1;
		r[2]  = mix.co3[7:0]   + mix.s1;
		r[3]  = mix.co1[23:16] + mix.s0;
		r[4]  = mix.co2[23:16] - mix.s1;
		r[5]  = mix.co3[23:16] - mix.s0;
		r[6]  = mix.co1[31:24] - mix.s0;
		r[7]  = mix.co0[7:0]   - mix.s1;
		r[8]  = mix.co3[15:8]  + mix.s0;
		r[9]  = mix.co2[31:24] - mix.s1;
		r[10] = mix.co0[15:8]  + mix.s0;
		r[11] = mix.co1[15:8]  - mix.s1;
		r[12] = mix.co1[7:0]   + mix.s1;
		r[13] = mix.co3[31:24] + mix.s1;
		r[14] = mix.co2[7:0]   + mix.s0;
		r[15] = mix.co0[31:24] - mix.s0;
	end

	always_comb begin
		lo = '0;
		hi = '0;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = r[i] ^ mix.seed_out;
			hi[8*i +: 8] = r[i+8] ^ mix.seed_out;
		end
	end

endmodule

// ===== test/tb_colorimeter_unlock_response_unit.sv =====
`timescale 1ns / 1ps

module tb_colorimeter_unlock_response_unit;
	import cur_pkg::*;

	localparam int REG_KEY_FIRST  = 0;
	localparam int REG_KEY_SECOND = 1;
	localparam int N_PHASES       = 8;
	localparam int PHASE_WORDS    = 185;
	localparam int CALM_TAIL      = 300;
	localparam int STALL_LIMIT    = 200;
	localparam int N_DIRECTED     = 16;

	typedef struct packed {
		logic [7:0]  tag;
		logic [7:0]  sout;
		logic [7:0]  sin;
		logic [63:0] ch;
	} chal_t;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic        bad;
	} resp_t;

	typedef struct packed {
		chal_t c;
		bit    typed;
		resp_t r;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  reply_tag = '0;
	logic [7:0]  seed_out = '0;
	logic [7:0]  seed_in = '0;
	logic [63:0] challenge_bytes = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        busy;
	logic        done;
	logic [63:0] response_low;
	logic [63:0] response_high;
	logic        bad_reply;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] key_first_r = '0;
	logic [31:0] key_second_r = '0;
	resp_t       resp_q [$];
	resp_t       want;
	int          n_words = 0;
	int          n_bad_tags = 0;
	int          n_checked = 0;
	int          n_errors = 0;
	int          stall_cnt = 0;

	dir_row_t dir_tab [N_DIRECTED] = '{
		'{'{8'h00, 8'h00, 8'h00, 64'h0}, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{'{8'h99, 8'h00, 8'h00, 64'h0}, 1'b1, '{64'h0, 64'h0, 1'b0}},
		'{'{8'h99, 8'hFF, 8'h00, 64'h0}, 1'b1, '{'1, '1, 1'b0}},
		'{'{8'hFF, 8'hFF, 8'h00, 64'h0}, 1'b1, '{'1, '1, 1'b1}},
		'{'{8'h98, 8'h00, 8'h00, 64'h0}, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{'{8'h9A, 8'h00, 8'h00, 64'h0}, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{'{8'h99, 8'h5A, 8'hFF, '1}, 1'b1, '{{8{8'h5A}}, {8{8'h5A}}, 1'b0}},
		'{'{8'h99, 8'h00, 8'h00, '1}, 1'b0, '0},
		'{'{8'h99, 8'h00, 8'hFF, 64'h0}, 1'b0, '0},
		'{'{8'h99, 8'h00, 8'h00, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
		'{'{8'h99, 8'hA5, 8'h3C, 64'hFEDC_BA98_7654_3210}, 1'b0, '0},
		'{'{8'h99, 8'h00, 8'h00, 64'h8000_0000_0000_0001}, 1'b0, '0},
		'{'{8'h99, 8'hFF, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFE}, 1'b0, '0},
		'{'{8'h66, 8'h81, 8'h7E, 64'h0F0F_0F0F_F0F0_F0F0}, 1'b0, '0},
		'{'{8'h99, 8'h01, 8'h80, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
		'{'{8'h99, 8'h80, 8'h01, 64'h5555_5555_5555_5555}, 1'b0, '0}
	};

	colorimeter_unlock_response_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.reply_tag       (reply_tag),
		.seed_out        (seed_out),
		.seed_in         (seed_in),
		.challenge_bytes (challenge_bytes),
		.done            (done),
		.response_low    (response_low),
		.response_high   (response_high),
		.bad_reply       (bad_reply),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic resp_t predict_response(input chal_t c);
		logic [7:0]  sc [8];
		logic [31:0] ci0, ci1, nk0, nk1;
		logic [31:0] co [4];
		logic [7:0]  kt0, kt1, s0, s1;
		logic [15:0] total;
		logic [7:0]  r [16];
		resp_t       res;
		for (int i = 0; i < 8; i++)
			sc[i] = c.ch[8*i +: 8] ^ c.sin;
		ci0 = {sc[3], sc[0], sc[4], sc[6]};
		ci1 = {sc[1], sc[7], sc[2], sc[5]};
		nk0 = 32'd0 - key_first_r;
		nk1 = 32'd0 - key_second_r;
		co[0] = nk0 - ci1;
		co[1] = nk1 - ci0;
		co[2] = ci1 * nk0;
		co[3] = ci0 * nk1;
		kt0 = '0;
		kt1 = '0;
		for (int k = 0; k < 4; k++) begin
			kt0 += nk0[8*k +: 8];
			kt1 += nk1[8*k +: 8];
		end
		total = '0;
		for (int i = 0; i < 8; i++)
			total += sc[i];
		total += kt0;
		total += kt1;
		s0 = total[7:0];
		s1 = total[15:8];
		r[0]  = co[0][23:16] + s0;
		r[1]  = co[2][15:8]  - s1;
		r[2]  = co[3][7:0]   + s1;
		r[3]  = co[1][23:16] + s0;
		r[4]  = co[2][23:16] - s1;
		r[5]  = co[3][23:16] - s0;
		r[6]  = co[1][31:24] - s0;
		r[7]  = co[0][7:0]   - s1;
		r[8]  = co[3][15:8]  + s0;
		r[9]  = co[2][31:24] - s1;
		r[10] = co[0][15:8]  + s0;
		r[11] = co[1][15:8]  - s1;
		r[12] = co[1][7:0]   + s1;
		r[13] = co[3][31:24] + s1;
		r[14] = co[2][7:0]   + s0;
		r[15] = co[0][31:24] - s0;
		for (int i = 0; i < 8; i++) begin
			res.lo[8*i +: 8] = r[i] ^ c.sout;
			res.hi[8*i +: 8] = r[i+8] ^ c.sout;
		end
		res.bad = (c.tag != TAG_EXPECTED);
		return res;
	endfunction

	function automatic chal_t rand_word();
		chal_t c;
		c.tag = ($urandom_range(0, 7) == 0) ? 8'($urandom) : TAG_EXPECTED;
		c.sout = 8'($urandom);
		c.sin = 8'($urandom);
		case ($urandom_range(0, 11))
			0: c.ch = '0;
			1: c.ch = '1;
			2: c.ch = 64'd1 << $urandom_range(0, 63);
			3: c.ch = {8{c.sin}};
			default: c.ch = {$urandom, $urandom};
		endcase
		return c;
	endfunction

	task automatic send_word(input chal_t c, input bit typed, input resp_t typed_r);
		start <= 1'b1;
		reply_tag <= c.tag;
		seed_out <= c.sout;
		seed_in <= c.sin;
		challenge_bytes <= c.ch;
		do @(posedge clk); while (busy);
		resp_q.push_back(typed ? typed_r : predict_response(c));
		n_words++;
		if (c.tag != TAG_EXPECTED)
			n_bad_tags++;
	endtask

	task automatic idle_burst(input int n);
		chal_t junk;
		junk = rand_word();
		start <= 1'b0;
		reply_tag <= junk.tag;
		seed_out <= junk.sout;
		seed_in <= junk.sin;
		challenge_bytes <= junk.ch;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(input int idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx << 2);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_KEY_FIRST)
			key_first_r = val;
		else if (idx == REG_KEY_SECOND)
			key_second_r = val;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (resp_q.size() == 0) begin
				n_errors++;
				$display("%0t: response word with nothing expected: lo=%h hi=%h bad=%b",
					$time, response_low, response_high, bad_reply);
			end else begin
				want = resp_q.pop_front();
				n_checked++;
				if (response_low !== want.lo) begin
					n_errors++;
					$display("%0t: response_low expected %h actual %h",
						$time, want.lo, response_low);
				end
				if (response_high !== want.hi) begin
					n_errors++;
					$display("%0t: response_high expected %h actual %h",
						$time, want.hi, response_high);
				end
				if (bad_reply !== want.bad) begin
					n_errors++;
					$display("%0t: bad_reply expected %b actual %b",
						$time, want.bad, bad_reply);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [31:0] kf, ks;
		bit          may_idle;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					kf = '1;
					ks = '1;
				end
				1: begin
					kf = 32'h0000_0001;
					ks = 32'h8000_0000;
				end
				2: begin
					kf = 32'h8000_0000;
					ks = 32'h0000_0001;
				end
				3: begin
					kf = 32'h7FFF_FFFF;
					ks = 32'hFFFF_FFFE;
				end
				N_PHASES - 1: begin
					kf = '0;
					ks = '0;
				end
				default: begin
					kf = $urandom;
					ks = $urandom;
				end
			endcase
			// Keys may only change once the pipeline has emptied.
			drain_results();
			write_key(REG_KEY_FIRST, kf);
			write_key(REG_KEY_SECOND, ks);
			for (int j = 0; j < PHASE_WORDS; j++) begin
				if (p == 2 && j == PHASE_WORDS / 2)
					drain_results();
				may_idle = (p % 3 != 1) &&
					(n_words < N_DIRECTED + N_PHASES * PHASE_WORDS - CALM_TAIL);
				if (may_idle && $urandom_range(0, 3) == 0)
					idle_burst($urandom_range(1, 6));
				send_word(rand_word(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("Sent %0d challenge words under %0d key settings, %0d with a bad reply tag.",
			n_words, N_PHASES + 1, n_bad_tags);
		$display("Checked %0d responses, %0d field mismatches.", n_checked, n_errors);
		if (n_errors == 0 && resp_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
